// File: design/wwm_pkg.sv
// shared types and constants of the weighted window mean filter
`default_nettype none

package wwm_pkg;

  // widths fixed by the item fields
  localparam int SAMPLE_W = 16;
  localparam int WLEN_W   = 6;
  localparam int WEIGHT_W = 8;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;

  // configuration register indexes
  localparam logic CFG_WINDOW_LEN = 1'b0;
  localparam logic CFG_WEIGHT     = 1'b1;

  // item kinds carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_FILL,
    ST_WALK,
    ST_STORE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } wwm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic calc_len;
    logic fill_wr;
    logic walk;
    logic store;
    logic prep_div;
    logic div_step;
    logic load_out;
  } wwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_fill;
    logic fill_last;
    logic walk_last;
    logic div_last;
    logic out_free;
  } wwm_sts_t;

endpackage

`default_nettype wire

// File: design/wwm_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module wwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/wwm_ctrl.sv
// control state machine of the weighted window mean filter
`default_nettype none

module wwm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output wwm_pkg::wwm_cmd_t      cmd,
  input  wire wwm_pkg::wwm_sts_t sts
);

  wwm_pkg::wwm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wwm_pkg::ST_IDLE:  if (in_valid) state_next = wwm_pkg::ST_LEN;
      wwm_pkg::ST_LEN:   state_next = sts.is_fill ? wwm_pkg::ST_FILL : wwm_pkg::ST_WALK;
      wwm_pkg::ST_FILL:  if (sts.fill_last) state_next = wwm_pkg::ST_IDLE;
      wwm_pkg::ST_WALK:  if (sts.walk_last) state_next = wwm_pkg::ST_STORE;
      wwm_pkg::ST_STORE: state_next = wwm_pkg::ST_PREP;
      wwm_pkg::ST_PREP:  state_next = wwm_pkg::ST_DIV;
      wwm_pkg::ST_DIV:   if (sts.div_last) state_next = wwm_pkg::ST_DONE;
      wwm_pkg::ST_DONE:  if (sts.out_free) state_next = wwm_pkg::ST_IDLE;
      default:           state_next = wwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      wwm_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      wwm_pkg::ST_LEN:   cmd.calc_len = !sts.is_fill;
      wwm_pkg::ST_FILL:  cmd.fill_wr  = 1'b1;
      wwm_pkg::ST_WALK:  cmd.walk     = 1'b1;
      wwm_pkg::ST_STORE: cmd.store    = 1'b1;
      wwm_pkg::ST_PREP:  cmd.prep_div = 1'b1;
      wwm_pkg::ST_DIV:   cmd.div_step = 1'b1;
      wwm_pkg::ST_DONE:  cmd.load_out = sts.out_free;
      default:           cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/wwm_dpath.sv
// datapath: config registers, history ram, running sum, divider, output register
`default_nettype none

module wwm_dpath #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_index,
  input  wire logic [wwm_pkg::WEIGHT_W-1:0]  cfg_data,
  input  wire logic                          in_cmd,
  input  wire logic [wwm_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [wwm_pkg::SAMPLE_W-1:0]  out_data,
  input  wire wwm_pkg::wwm_cmd_t             cmd,
  output wwm_pkg::wwm_sts_t                  sts
);

  localparam int DEPTH  = MAX_WINDOW + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (ADDR_W > wwm_pkg::WLEN_W) ? ADDR_W : wwm_pkg::WLEN_W;
  localparam int DIV_W  = $clog2(MAX_WINDOW + 256);
  localparam int SUM_W  = wwm_pkg::SAMPLE_W + DIV_W;
  localparam int DCNT_W = $clog2(SUM_W);

  // config registers
  logic [wwm_pkg::WLEN_W-1:0]   window_len;
  logic [wwm_pkg::WEIGHT_W-1:0] weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= '0;
      weight     <= wwm_pkg::WEIGHT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        wwm_pkg::CFG_WINDOW_LEN: window_len <= cfg_data[wwm_pkg::WLEN_W-1:0];
        wwm_pkg::CFG_WEIGHT:     weight     <= cfg_data;
        default:                 weight     <= weight;
      endcase
    end
  end

  // item capture
  logic                                item_cmd;
  logic signed [wwm_pkg::SAMPLE_W-1:0] item_sample;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd    <= in_cmd;
      item_sample <= in_sample;
    end
  end

  // fill count and working length
  logic [ADDR_W-1:0] fill_count, fill_count_next, len;
  logic [CMP_W-1:0]  wl_ext, fc_ext;

  always_comb begin
    wl_ext = CMP_W'(window_len);
    fc_ext = CMP_W'(fill_count);
    if (wl_ext > fc_ext) begin
      if (fc_ext < CMP_W'(MAX_WINDOW)) begin
        fill_count_next = fill_count + ADDR_W'(1);
      end else begin
        fill_count_next = fill_count;
      end
    end else begin
      fill_count_next = ADDR_W'(wl_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.calc_len) begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_len) begin
      len <= fill_count_next;
    end
  end

  // history ram with valid bits; an entry never written reads as zero
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [wwm_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata, hist_data;
  logic [DEPTH-1:0]            vld;
  logic                        rd_vld;
  logic [ADDR_W-1:0]           idx;

  wwm_ram #(
    .WIDTH (wwm_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hist_data = rd_vld ? ram_rdata : '0;
  assign ram_raddr = idx + ADDR_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = item_sample;
    if (cmd.fill_wr) begin
      ram_we = 1'b1;
    end else if (cmd.walk && idx != '0) begin
      // entry idx arrived from the read issued last cycle, move it down one place
      ram_we    = 1'b1;
      ram_waddr = idx - ADDR_W'(1);
      ram_wdata = hist_data;
    end else if (cmd.store) begin
      ram_we    = 1'b1;
      ram_waddr = len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[ram_raddr];
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      idx <= '0;
    end else if (cmd.fill_wr || cmd.walk) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // running sum and weighted newest sample
  logic signed [SUM_W-1:0]          acc, total;
  logic signed [wwm_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (cmd.calc_len) begin
      acc <= '0;
    end else if (cmd.walk && idx != '0) begin
      acc <= acc + SUM_W'($signed(hist_data));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      prod <= wwm_pkg::PROD_W'($signed({1'b0, weight})) * wwm_pkg::PROD_W'(item_sample);
    end
  end

  assign total = acc + SUM_W'(prod);

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [SUM_W-1:0]  quo, quo_signed;
  logic [DIV_W-1:0]  rem, dvs;
  logic [DIV_W:0]    rem_sh;
  logic              neg, dzero;
  logic [DCNT_W-1:0] dcnt;

  assign rem_sh = {rem, quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.prep_div) begin
      neg   <= total[SUM_W-1];
      quo   <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
      rem   <= '0;
      dvs   <= DIV_W'(len) + DIV_W'(weight);
      dzero <= (len == '0) && (weight == '0);
      dcnt  <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DCNT_W'(1);
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DIV_W'(rem_sh - {1'b0, dvs});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo_signed = neg ? (~quo + SUM_W'(1)) : quo;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= dzero ? '0 : quo_signed[wwm_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    sts.is_fill   = (item_cmd == wwm_pkg::CMD_FILL);
    sts.fill_last = (idx == ADDR_W'(MAX_WINDOW - 1));
    sts.walk_last = (idx == len);
    sts.div_last  = (dcnt == DCNT_W'(SUM_W - 1));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// File: design/weighted_window_mean.sv
// top level of the weighted window mean smoothing filter
// sample item: accept, length update, history walk, store, divider prep, divide, then
//   the result goes to the output register once it is free
// fill item: one history write per cycle into the first MAX_WINDOW entries, no result
// one item at a time: the next item is accepted only after the last one is through
// reset clears the fill count and every history valid bit (history reads as zero),
//   window_len to 0 and weight to 1; no clearing pass is needed
`default_nettype none

module weighted_window_mean #(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes, always ready
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,     // 0 window_len, 1 weight
  input  wire logic [7:0]  cfg_data,      // window_len in [5:0], weight in [7:0]
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] sample
  input  wire logic        s_axis_tuser,  // [0] cmd: 0 filter sample, 1 fill history
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata   // [15:0] average
);

  wwm_pkg::wwm_cmd_t cmd;
  wwm_pkg::wwm_sts_t sts;

  // each write goes straight into its register, so the write channel never stalls
  assign cfg_ready = 1'b1;

  // sequencer: decode, history fill or walk, store, divide, hand off
  wwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // storage and arithmetic; the output register lets a result wait while
  // the sequencer returns to idle
  wwm_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_cmd    (s_axis_tuser),
    .in_sample (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// File: design/wwm_checker.sv
// port-level checks of the weighted window mean filter, bound to the top level
`default_nettype none

module wwm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // no result is left over from before reset
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after accept");

  // a result needs the walk and the divide, so none appears straight after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
    else $error("result too soon after accept");

endmodule

bind weighted_window_mean wwm_checker u_wwm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/sv/weighted_window_mean_test.sv
// self-checking testbench for the weighted window mean filter
`timescale 1ns / 100ps

module weighted_window_mean_test;

  localparam int MAX_WINDOW     = 32;
  // a fill item is busy with no result, so wait out a trailing one with a margin
  localparam int SETTLE_CYCLES  = MAX_WINDOW + 8;
  // longest correct quiet stretch is one sample item plus a stall or a gap
  localparam int QUIET_LIMIT    = 5000;
  localparam int PHASES         = 12;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int REPORT_MAX     = 100;

  // expected averages and the filter state they are derived from
  class window_mean_board;
    logic signed [15:0] history [0:MAX_WINDOW];
    logic [5:0]         fill_count;
    logic [5:0]         window_len;
    logic [7:0]         weight;
    logic signed [15:0] expected_avg [$];
    int                 errors;
    int                 checked;
    int                 samples;
    int                 fills;
    int                 reg_writes;

    function new();
      foreach (history[i]) history[i] = '0;
      fill_count = '0;
      window_len = '0;
      weight     = 8'd1;
      errors     = 0;
      checked    = 0;
      samples    = 0;
      fills      = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(logic index, logic [7:0] data);
      reg_writes++;
      if (index == wwm_pkg::CFG_WINDOW_LEN) window_len = data[5:0];
      else                                  weight     = data;
    endfunction

    // accepted input item: update the history and queue the average it gives
    function void note_item(logic cmd, logic signed [15:0] value);
      int unsigned len;
      longint      acc;
      longint      divisor;
      longint      q;
      if (cmd == wwm_pkg::CMD_FILL) begin
        // last entry and the fill count are left alone
        for (int i = 0; i < MAX_WINDOW; i++) history[i] = value;
        fills++;
        return;
      end
      samples++;
      if (window_len > fill_count) begin
        if (fill_count < MAX_WINDOW) fill_count++;
      end else begin
        // window shrank (or held): count drops to the window
        fill_count = window_len;
      end
      len = fill_count;
      if (len > MAX_WINDOW) len = MAX_WINDOW;
      acc = 0;
      for (int i = 0; i < len; i++) begin
        history[i] = history[i+1];
        acc += history[i];
      end
      history[len] = value;
      acc += longint'(weight) * longint'(value);
      divisor = longint'(len) + longint'(weight);
      // zero weight with an empty window gives zero
      q = (divisor == 0) ? 0 : acc / divisor;
      if (q > 32767)  q = 32767;
      if (q < -32768) q = -32768;
      expected_avg.push_back(q[15:0]);
    endfunction

    function void check_average(logic signed [15:0] got);
      logic signed [15:0] want;
      checked++;
      if (expected_avg.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected average %0d with nothing pending", $realtime, got);
        return;
      end
      want = expected_avg.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: average mismatch, expected %0d, got %0d", $realtime, want, got);
      end
    endfunction

    function int pending();
      return expected_avg.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = wwm_pkg::CFG_WINDOW_LEN;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] sample
  logic        s_axis_tuser = wwm_pkg::CMD_SAMPLE;  // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] average

  window_mean_board sb = new();

  // idling in percent of cycles, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic signed [15:0] level = '0;

  weighted_window_mean #(.MAX_WINDOW(MAX_WINDOW)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random stalls, every accepted item checked against the oldest expectation
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_average(m_axis_tdata);
  end

  // watchdog on cycles where no handshake completes anywhere
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("weighted_window_mean_test failed");
        $finish;
      end
    end
  end

  // write both registers back to back, block must be idle
  task automatic configure(input logic [5:0] wlen, input logic [7:0] wt);
    cfg_valid <= 1'b1;
    cfg_index <= wwm_pkg::CFG_WINDOW_LEN;
    cfg_data  <= {2'b00, wlen};
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(wwm_pkg::CFG_WINDOW_LEN, {2'b00, wlen});
    cfg_index <= wwm_pkg::CFG_WEIGHT;
    cfg_data  <= wt;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(wwm_pkg::CFG_WEIGHT, wt);
    cfg_valid <= 1'b0;
  endtask

  // one input item; valid stays high into the next item unless a gap is taken
  task automatic send_item(input logic cmd, input logic [15:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, value);
  endtask

  // drain every expected average, then let a trailing fill item finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_window();
    case ($urandom_range(7))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd32;
      3:       return 6'($urandom_range(33, 63));   // beyond the history, count saturates
      default: return 6'($urandom_range(2, 31));
    endcase
  endfunction

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // mix of full-range noise, rail values and a slowly drifting signal
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff - 16'($urandom_range(3));
      1:       return 16'h8000 + 16'($urandom_range(3));
      2, 3, 4: return 16'($urandom_range(65535));
      default: begin
        level = level + 16'(signed'(8'($urandom_range(255))));
        return level;
      end
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset-like settings, empty window gives the sample itself
    configure(6'd0, 8'd1);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h8000);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h7fff);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h0000);
    settle();
    // full window and largest weight, filled with both rails
    configure(6'd32, 8'd255);
    send_item(wwm_pkg::CMD_FILL,   16'h7fff);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h7fff);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h7fff);
    send_item(wwm_pkg::CMD_FILL,   16'h8000);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h8000);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h0001);
    settle();
    // window longer than the history
    configure(6'd63, 8'd1);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h7fff);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h8000);
    send_item(wwm_pkg::CMD_SAMPLE, 16'd12345);
    settle();
    // window one above the fill count: count grows to the window, then holds
    configure(6'd8, 8'd1);
    send_item(wwm_pkg::CMD_SAMPLE, 16'd100);
    send_item(wwm_pkg::CMD_SAMPLE, -16'sd100);
    settle();
    // zero weight with empty window: divisor zero
    configure(6'd0, 8'd0);
    send_item(wwm_pkg::CMD_SAMPLE, 16'd1234);
    send_item(wwm_pkg::CMD_SAMPLE, 16'hffff);
    settle();
    // zero weight, new sample adds nothing
    configure(6'd5, 8'd0);
    send_item(wwm_pkg::CMD_SAMPLE, 16'd500);
    send_item(wwm_pkg::CMD_SAMPLE, 16'd700);
    settle();
    configure(6'd1, 8'd255);
    send_item(wwm_pkg::CMD_FILL,   16'h0000);
    send_item(wwm_pkg::CMD_SAMPLE, 16'h8000);
    settle();

    // random phases, cycling through the idling modes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      configure(pick_window(), pick_weight());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 8) send_item(wwm_pkg::CMD_FILL, pick_sample());
        else                        send_item(wwm_pkg::CMD_SAMPLE, pick_sample());
      end
      settle();
    end

    $display("covered %0d sample and %0d fill items, %0d averages checked, %0d register writes",
             sb.samples, sb.fills, sb.checked, sb.reg_writes);
    $display("windows 0 to 63, weights 0 to 255, four idling modes; %0d errors", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("weighted_window_mean_test passed");
    end else begin
      $display("weighted_window_mean_test failed");
    end
    $finish;
  end

endmodule

// File: weighted_window_mean.f
design/wwm_pkg.sv
design/wwm_ram.sv
design/wwm_ctrl.sv
design/wwm_dpath.sv
design/weighted_window_mean.sv
design/wwm_checker.sv
tb/sv/weighted_window_mean_test.sv
